// ----- rtl/lawsplit_pkg.sv -----
// Package with the constants, types and command/status structs of the large-array work splitter.
`timescale 1ns / 1ps
package lawsplit_pkg;

  localparam int unsigned PieceShift  = 12;
  localparam int unsigned AddrBits    = 44;
  localparam int unsigned AddrW       = 44;
  localparam int unsigned SizeW       = 34;
  localparam int unsigned MidW        = AddrW + 1;
  localparam int unsigned UnitW       = SizeW - PieceShift;
  localparam int unsigned MaxHalvings = 23;
  localparam int unsigned HcntW       = $clog2(MaxHalvings + 1);

  localparam logic [SizeW-1:0] PieceSize =
    {{(SizeW - PieceShift - 1){1'b0}}, 1'b1, {PieceShift{1'b0}}};
  localparam logic [AddrW-1:0] AddrMask =
    (AddrBits >= AddrW) ? {AddrW{1'b1}} : AddrW'((64'd1 << AddrBits) - 64'd1);
  localparam logic [HcntW-1:0] HcntLast = HcntW'(MaxHalvings - 1);

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StTail,
    StMid,
    StLead
  } state_e;

  typedef enum logic [1:0] {
    SelTail,
    SelMid,
    SelLead
  } sel_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic emit;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic tail_nz;
    logic rem_nz;
    logic rem_last;
    logic slot_free;
  } stat_t;

endpackage

// ----- rtl/lawsplit_dp.sv -----
// Datapath of the work splitter: array registers, split arithmetic and the output register.
`timescale 1ns / 1ps
module lawsplit_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lawsplit_pkg::cmd_t              cmd_i,
  output lawsplit_pkg::stat_t             stat_o,
  input  logic [lawsplit_pkg::AddrW-1:0]  array_start_i,
  input  logic [lawsplit_pkg::SizeW-1:0]  array_size_i,
  input  logic                            finalizable_i,
  output logic                            piece_valid_o,
  input  logic                            piece_ready_i,
  output logic [lawsplit_pkg::AddrW-1:0]  piece_addr_o,
  output logic [lawsplit_pkg::SizeW-1:0]  piece_size_o,
  output logic                            piece_kind_o,
  output logic                            piece_finalizable_o,
  output logic                            last_piece_o
);
  import lawsplit_pkg::*;

  logic [AddrW-1:0]      start_q;
  logic [SizeW-1:0]      size_q;
  logic                  fin_q;
  logic [MidW-1:0]       mid_start_q;
  logic [UnitW-1:0]      rem_q, rem_d;
  logic [PieceShift-1:0] tail_q;
  logic [SizeW-1:0]      lead_q;
  logic [HcntW-1:0]      hcnt_q, hcnt_d;

  logic [SizeW-1:0]      lead_nrm;
  logic [SizeW-1:0]      body;
  logic                  one_piece;
  logic [UnitW-1:0]      half_u, part_u, new_u;
  logic                  capped;

  logic                  out_valid_q;
  logic [AddrW-1:0]      out_addr_q;
  logic [SizeW-1:0]      out_size_q;
  logic                  out_kind_q, out_fin_q, out_last_q;
  logic [MidW-1:0]       emit_sum;
  logic [SizeW-1:0]      emit_size;
  logic                  emit_kind;

  always_comb begin
    lead_nrm  = PieceSize - SizeW'(start_q[PieceShift-1:0]);
    one_piece = (size_q <= PieceSize);
    body      = size_q - lead_nrm;
    half_u    = rem_q >> 1;
    capped    = (hcnt_q == HcntLast);
    part_u    = capped ? rem_q : (rem_q - half_u);
    new_u     = capped ? '0 : half_u;
  end

  always_comb begin
    emit_sum  = MidW'(start_q);
    emit_size = lead_q;
    emit_kind = 1'b1;
    unique case (cmd_i.sel)
      SelTail: begin
        emit_sum  = mid_start_q + MidW'({rem_q, {PieceShift{1'b0}}});
        emit_size = SizeW'(tail_q);
        emit_kind = 1'b0;
      end
      SelMid: begin
        emit_sum  = mid_start_q + MidW'({new_u, {PieceShift{1'b0}}});
        emit_size = {part_u, {PieceShift{1'b0}}};
        emit_kind = 1'b0;
      end
      SelLead: begin
        emit_sum  = MidW'(start_q);
        emit_size = lead_q;
        emit_kind = 1'b1;
      end
      default: begin
        emit_sum  = MidW'(start_q);
        emit_size = lead_q;
        emit_kind = 1'b1;
      end
    endcase
  end

  always_comb begin
    rem_d  = rem_q;
    hcnt_d = hcnt_q;
    if (cmd_i.setup) begin
      rem_d  = one_piece ? '0 : body[SizeW-1:PieceShift];
      hcnt_d = '0;
    end else if (cmd_i.emit && (cmd_i.sel == SelMid)) begin
      rem_d  = new_u;
      hcnt_d = hcnt_q + HcntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    hcnt_q <= hcnt_d;
    if (cmd_i.load) begin
      start_q <= array_start_i;
      size_q  <= array_size_i;
      fin_q   <= finalizable_i;
    end
    if (cmd_i.setup) begin
      mid_start_q <= MidW'(start_q) + MidW'(lead_nrm);
      tail_q      <= one_piece ? '0 : body[PieceShift-1:0];
      lead_q      <= one_piece ? size_q : lead_nrm;
    end
    if (cmd_i.emit) begin
      out_addr_q <= emit_sum[AddrW-1:0] & AddrMask;
      out_size_q <= emit_size;
      out_kind_q <= emit_kind;
      out_fin_q  <= fin_q;
      out_last_q <= (cmd_i.sel == SelLead);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (piece_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.tail_nz   = (tail_q != '0);
  assign stat_o.rem_nz    = (rem_q != '0);
  assign stat_o.rem_last  = capped || (half_u == '0);
  assign stat_o.slot_free = !out_valid_q || piece_ready_i;

  assign piece_valid_o       = out_valid_q;
  assign piece_addr_o        = out_addr_q;
  assign piece_size_o        = out_size_q;
  assign piece_kind_o        = out_kind_q;
  assign piece_finalizable_o = out_fin_q;
  assign last_piece_o        = out_last_q;

endmodule

// ----- rtl/lawsplit_ctrl.sv -----
// Controller state machine that sequences the trailing, middle and leading pieces.
`timescale 1ns / 1ps
module lawsplit_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 array_valid_i,
  output logic                 array_ready_o,
  input  lawsplit_pkg::stat_t  stat_i,
  output lawsplit_pkg::cmd_t   cmd_o
);
  import lawsplit_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    array_ready_o = 1'b0;
    cmd_o         = '{load: 1'b0, setup: 1'b0, emit: 1'b0, sel: SelLead};
    unique case (state_q)
      StIdle: begin
        array_ready_o = 1'b1;
        if (array_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSetup;
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = StTail;
      end
      StTail: begin
        cmd_o.sel = SelTail;
        if (!stat_i.tail_nz) begin
          state_d = stat_i.rem_nz ? StMid : StLead;
        end else if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.rem_nz ? StMid : StLead;
        end
      end
      StMid: begin
        cmd_o.sel = SelMid;
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.rem_last ? StLead : StMid;
        end
      end
      StLead: begin
        cmd_o.sel = SelLead;
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ----- rtl/large_array_work_splitter.sv -----
// Top level of the large-array work splitter: controller, datapath and checks.
// First piece: an accepted array passes the setup state, then the trailing state, which
// sends the first piece at the soonest; with no trailing part it comes from the middle or leading state.
// Throughput: one array at a time; after the load and the setup state the trailing state is
// always visited, piece sent or not, and the rest leave at one a cycle while the output
// slot is free.
// Reset: rst_ni clears the state machine and the output valid flag; no piece is pending.
`timescale 1ns / 1ps
module large_array_work_splitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            array_valid_i,
  output logic                            array_ready_o,
  input  logic [lawsplit_pkg::AddrW-1:0]  array_start_i,
  input  logic [lawsplit_pkg::SizeW-1:0]  array_size_i,
  input  logic                            finalizable_i,
  output logic                            piece_valid_o,
  input  logic                            piece_ready_i,
  output logic [lawsplit_pkg::AddrW-1:0]  piece_addr_o,
  output logic [lawsplit_pkg::SizeW-1:0]  piece_size_o,
  output logic                            piece_kind_o,
  output logic                            piece_finalizable_o,
  output logic                            last_piece_o
);
  import lawsplit_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lawsplit_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .array_valid_i (array_valid_i),
    .array_ready_o (array_ready_o),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  lawsplit_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .array_start_i       (array_start_i),
    .array_size_i        (array_size_i),
    .finalizable_i       (finalizable_i),
    .piece_valid_o       (piece_valid_o),
    .piece_ready_i       (piece_ready_i),
    .piece_addr_o        (piece_addr_o),
    .piece_size_o        (piece_size_o),
    .piece_kind_o        (piece_kind_o),
    .piece_finalizable_o (piece_finalizable_o),
    .last_piece_o        (last_piece_o)
  );

  a_one_array: assert property (@(posedge clk_i) disable iff (!rst_ni)
    array_valid_i && array_ready_o |=> !array_ready_o)
    else $error("A second array beat was taken while one was being split.");

  a_last_is_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    piece_valid_o && last_piece_o |-> piece_kind_o)
    else $error("The final piece of an array was not a scan-now piece.");

  a_pushed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    piece_valid_o && !piece_kind_o |-> (piece_size_o != '0) && !last_piece_o)
    else $error("A pushed piece was empty or flagged as the final piece.");

endmodule
